@@ sv/grf_pkg.sv @@
package grf_pkg;

    // Default geometry limits.
    localparam int MAX_SIDE_DEF  = 32;
    localparam int MAX_CELLS_DEF = 1024;

    // Field widths fixed by the interface.
    localparam int CMD_W     = 2;
    localparam int CELL_W    = 10;
    localparam int SIDES_W   = 4;
    localparam int STEPS_W   = 8;
    localparam int COUNT_W   = 10;
    localparam int BACK_W    = 2;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // Board size after reset.
    localparam logic [CFG_W-1:0] BOARD_RESET = CFG_W'(32);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_HEIGHT = 1'b1;

    // Command codes of the input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    // Source of the next output word.
    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_ZERO,
        OUT_SEARCH,
        OUT_READ
    } t_out_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_we;
        logic     cap_req;
        logic     clr_step;
        logic     srch_init;
        logic     div_step;
        logic     seed;
        logic     pass_begin;
        logic     pass_end;
        logic     pop_rd;
        logic     nb_rd;
        logic     nb_eval;
        logic     rd_issue;
        t_out_sel out_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic start_ok;
        logic pass_zero;
        logic q_empty;
        logic pass_done;
        logic k_last;
    } t_dp_stat;

endpackage

@@ sv/grid_reach_flood_fill_core.sv @@
// Step-limited breadth-first flood fill over a loaded board. Loads and unknown
// commands return their word on acceptance; a read adds one record memory read. A
// search first clears the per-cell records, one entry per cycle over MAX_CELLS
// entries; then, if the start cell lies on the board, it locates the start row
// one row at a time from the top, and pops each frontier cell and reads and
// evaluates its four neighbours in turn, as the record and queue memories are
// single-port. After reset the same clearing pass over MAX_CELLS entries runs
// before the first word is accepted.
module grid_reach_flood_fill_core #(
    parameter int MAX_SIDE  = grf_pkg::MAX_SIDE_DEF,
    parameter int MAX_CELLS = grf_pkg::MAX_CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [grf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [grf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [grf_pkg::CMD_W-1:0]      i_cmd,
    input  logic [grf_pkg::CELL_W-1:0]     i_cell_req,
    input  logic                           i_occupied,
    input  logic                           i_has_floor,
    input  logic [grf_pkg::SIDES_W-1:0]    i_blocked_sides,
    input  logic [grf_pkg::STEPS_W-1:0]    i_step_budget,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_reached,
    output logic [grf_pkg::STEPS_W-1:0]    o_steps_left,
    output logic [grf_pkg::CELL_W-1:0]     o_parent_cell,
    output logic [grf_pkg::BACK_W-1:0]     o_back_side,
    output logic [grf_pkg::COUNT_W-1:0]    o_reached_count
);
    import grf_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer.
    grf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Memories, counters and output word.
    grf_dp #(
        .MAX_SIDE  (MAX_SIDE),
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_dp        (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cell_req      (i_cell_req),
        .i_occupied      (i_occupied),
        .i_has_floor     (i_has_floor),
        .i_blocked_sides (i_blocked_sides),
        .i_step_budget   (i_step_budget),
        .o_reached       (o_reached),
        .o_steps_left    (o_steps_left),
        .o_parent_cell   (o_parent_cell),
        .o_back_side     (o_back_side),
        .o_reached_count (o_reached_count)
    );

endmodule

@@ sv/grf_ctrl.sv @@
module grf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_cmd,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    input  grf_pkg::t_dp_stat  i_stat,
    output grf_pkg::t_dp_cmd   o_cmd
);
    import grf_pkg::*;

    typedef enum logic [3:0] {
        ST_RST_CLR,
        ST_IDLE,
        ST_RD_OUT,
        ST_CLR,
        ST_INIT,
        ST_CHECK,
        ST_DIV,
        ST_SEED,
        ST_PASS,
        ST_POP_CHK,
        ST_NB_RD,
        ST_NB_EVAL,
        ST_DONE
    } t_state;

    t_state   r_state, n_state;
    logic     r_out_valid, n_out_valid;
    logic     out_free;
    logic     accept;
    t_dp_cmd  cmd;

    // The output register can take a new word when empty or being drained.
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == ST_IDLE) && out_free);
    assign accept   = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_cmd    = cmd;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.out_sel = OUT_NONE;
        unique case (r_state)
            ST_RST_CLR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    priority case (i_cmd)
                        CMD_LOAD: begin
                            cmd.load_we = 1'b1;
                            cmd.out_sel = OUT_ZERO;
                        end
                        CMD_SEARCH: begin
                            cmd.cap_req = 1'b1;
                            n_state     = ST_CLR;
                        end
                        CMD_READ: begin
                            cmd.cap_req  = 1'b1;
                            cmd.rd_issue = 1'b1;
                            n_state      = ST_RD_OUT;
                        end
                        default: cmd.out_sel = OUT_ZERO;
                    endcase
                end
            end
            ST_RD_OUT: begin
                if (out_free) begin
                    cmd.out_sel = OUT_READ;
                    n_state     = ST_IDLE;
                end
            end
            ST_CLR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = ST_INIT;
            end
            ST_INIT: begin
                cmd.srch_init = 1'b1;
                n_state       = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_stat.start_ok ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (i_stat.div_done) n_state = ST_SEED;
                else cmd.div_step = 1'b1;
            end
            ST_SEED: begin
                cmd.seed = 1'b1;
                n_state  = ST_PASS;
            end
            ST_PASS: begin
                if (i_stat.pass_zero || i_stat.q_empty) begin
                    n_state = ST_DONE;
                end else begin
                    cmd.pass_begin = 1'b1;
                    n_state        = ST_POP_CHK;
                end
            end
            ST_POP_CHK: begin
                if (i_stat.pass_done) begin
                    cmd.pass_end = 1'b1;
                    n_state      = ST_PASS;
                end else begin
                    cmd.pop_rd = 1'b1;
                    n_state    = ST_NB_RD;
                end
            end
            ST_NB_RD: begin
                cmd.nb_rd = 1'b1;
                n_state   = ST_NB_EVAL;
            end
            ST_NB_EVAL: begin
                cmd.nb_eval = 1'b1;
                n_state     = i_stat.k_last ? ST_POP_CHK : ST_NB_RD;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_sel = OUT_SEARCH;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid follows loads into and drains from the output register.
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) n_out_valid = 1'b0;
        if (cmd.out_sel != OUT_NONE) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RST_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // A search never finishes in the cycle after it is accepted.
    a_search_not_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_SEARCH) |=> !o_valid)
        else $error("search word appeared right after acceptance");

    // Neighbour evaluation always follows its memory read.
    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NB_EVAL) |-> $past(r_state) == ST_NB_RD)
        else $error("neighbour evaluated without a read");

    // No input word is taken while a search is in flight.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS || r_state == ST_NB_RD || r_state == ST_CLR) |-> o_stall)
        else $error("input taken during a search");

endmodule

@@ sv/grf_dp.sv @@
module grf_dp #(
    parameter int MAX_SIDE  = grf_pkg::MAX_SIDE_DEF,
    parameter int MAX_CELLS = grf_pkg::MAX_CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  grf_pkg::t_dp_cmd               i_cmd_dp,
    output grf_pkg::t_dp_stat              o_stat,
    input  logic                           i_cfg_we,
    input  logic [grf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [grf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [grf_pkg::CELL_W-1:0]     i_cell_req,
    input  logic                           i_occupied,
    input  logic                           i_has_floor,
    input  logic [grf_pkg::SIDES_W-1:0]    i_blocked_sides,
    input  logic [grf_pkg::STEPS_W-1:0]    i_step_budget,
    output logic                           o_reached,
    output logic [grf_pkg::STEPS_W-1:0]    o_steps_left,
    output logic [grf_pkg::CELL_W-1:0]     o_parent_cell,
    output logic [grf_pkg::BACK_W-1:0]     o_back_side,
    output logic [grf_pkg::COUNT_W-1:0]    o_reached_count
);
    import grf_pkg::*;

    localparam int AW    = $clog2(MAX_CELLS);
    localparam int CW    = $clog2(MAX_CELLS + 1);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int RW    = $clog2(MAX_SIDE);
    localparam int QW    = AW + 2 * RW;
    localparam int MW    = 2 + SIDES_W;
    localparam int RECW  = 2 + STEPS_W + AW + BACK_W;
    localparam int REC_R = RECW - 1;
    localparam int REC_Q = RECW - 2;
    localparam int REC_S = RECW - 3;
    localparam int REC_P = AW + BACK_W - 1;

    // Configuration registers.
    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= BOARD_RESET;
            r_cfg_h <= BOARD_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_BOARD_WIDTH) r_cfg_w <= i_cfg_data;
            if (i_cfg_idx == REG_BOARD_HEIGHT) r_cfg_h <= i_cfg_data;
        end
    end

    // Clamp the board sides into one to MAX_SIDE.
    logic [SW-1:0] w, h;
    always_comb begin
        if (r_cfg_w == '0) w = SW'(1);
        else if (32'(r_cfg_w) > MAX_SIDE) w = SW'(MAX_SIDE);
        else w = SW'(r_cfg_w);
        if (r_cfg_h == '0) h = SW'(1);
        else if (32'(r_cfg_h) > MAX_SIDE) h = SW'(MAX_SIDE);
        else h = SW'(r_cfg_h);
    end

    logic [2*SW-1:0] area;
    assign area = (2*SW)'(w) * (2*SW)'(h);

    // Search control registers.
    logic [CELL_W-1:0]  r_req_cell;
    logic               r_req_in;
    logic [STEPS_W-1:0] r_pass;
    logic [CW-1:0]      r_cells, r_head, r_tail, r_end;
    logic [AW-1:0]      r_clr_addr, r_rem;
    logic [RW-1:0]      r_row;
    logic [1:0]         r_k;
    logic [COUNT_W-1:0] r_count;

    // Memories and their read registers.
    logic [MW-1:0]   r_map [MAX_CELLS];
    logic [RECW-1:0] r_rec [MAX_CELLS];
    logic [QW-1:0]   r_q   [MAX_CELLS];
    logic [MW-1:0]   r_map_q;
    logic [RECW-1:0] r_rec_q;
    logic [QW-1:0]   r_q_q;

    // Neighbour registers.
    logic [AW-1:0] r_nb;
    logic [RW-1:0] r_nrow, r_ncol;
    logic          r_nb_ok;

    // Current frontier cell comes straight from the queue read register.
    logic [AW-1:0] cur_idx;
    logic [RW-1:0] cur_row, cur_col;
    assign cur_idx = r_q_q[QW-1 -: AW];
    assign cur_row = r_q_q[2*RW-1 -: RW];
    assign cur_col = r_q_q[RW-1:0];

    // Neighbour geometry for side r_k.
    logic [31:0]   nb_full;
    logic          nb_geo;
    logic [RW-1:0] nb_row, nb_col;
    always_comb begin
        nb_full = 32'(cur_idx);
        nb_geo  = 1'b0;
        nb_row  = cur_row;
        nb_col  = cur_col;
        unique case (r_k)
            2'd0: begin
                nb_geo  = cur_row != '0;
                nb_full = 32'(cur_idx) - 32'(w);
                nb_row  = cur_row - RW'(1);
            end
            2'd1: begin
                nb_geo  = 32'(cur_col) + 32'd1 < 32'(w);
                nb_full = 32'(cur_idx) + 32'd1;
                nb_col  = cur_col + RW'(1);
            end
            2'd2: begin
                nb_geo  = 32'(cur_row) + 32'd1 < 32'(h);
                nb_full = 32'(cur_idx) + 32'(w);
                nb_row  = cur_row + RW'(1);
            end
            2'd3: begin
                nb_geo  = cur_col != '0;
                nb_full = 32'(cur_idx) - 32'd1;
                nb_col  = cur_col - RW'(1);
            end
            default: nb_geo = 1'b0;
        endcase
    end

    // Claim test on the registered neighbour data.
    logic [1:0] opp;
    logic       claim;
    assign opp   = r_k + 2'd2;
    assign claim = i_cmd_dp.nb_eval && r_nb_ok && !r_rec_q[REC_Q] &&
                   !r_map_q[MW-1] && r_map_q[MW-2] && !r_map_q[opp];

    logic [AW-1:0] start_idx, rd_addr;
    assign start_idx = AW'(r_req_cell);
    assign rd_addr   = i_cmd_dp.nb_rd ? AW'(nb_full) : AW'(i_cell_req);

    // Cell map: written by loads, read per neighbour.
    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.load_we && 32'(i_cell_req) < MAX_CELLS)
            r_map[AW'(i_cell_req)] <= {i_occupied, i_has_floor, i_blocked_sides};
        if (i_cmd_dp.nb_rd) r_map_q <= r_map[AW'(nb_full)];
    end

    // Cell records: cleared, seeded, claimed; read per neighbour or by a read.
    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.clr_step) begin
            r_rec[r_clr_addr] <= '0;
        end else if (i_cmd_dp.seed) begin
            r_rec[start_idx] <= RECW'(1) << REC_Q;
        end else if (claim) begin
            r_rec[r_nb] <= {1'b1, 1'b1, r_pass - STEPS_W'(1), cur_idx, opp};
        end
        if (i_cmd_dp.nb_rd || i_cmd_dp.rd_issue) r_rec_q <= r_rec[rd_addr];
    end

    // Frontier queue with cell index, row and column.
    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.seed) r_q[r_tail[AW-1:0]] <= {start_idx, r_row, RW'(r_rem)};
        else if (claim) r_q[r_tail[AW-1:0]] <= {r_nb, r_nrow, r_ncol};
        if (i_cmd_dp.pop_rd) r_q_q <= r_q[r_head[AW-1:0]];
    end

    // Neighbour address capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.nb_rd) begin
            r_nb    <= AW'(nb_full);
            r_nrow  <= nb_row;
            r_ncol  <= nb_col;
            r_nb_ok <= nb_geo && nb_full < 32'(r_cells);
        end
    end

    // Search sequencing counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_end      <= '0;
            r_cells    <= '0;
            r_pass     <= '0;
            r_count    <= '0;
            r_k        <= '0;
            r_req_in   <= 1'b0;
        end else begin
            if (i_cmd_dp.cap_req) begin
                r_req_cell <= i_cell_req;
                r_req_in   <= 32'(i_cell_req) < MAX_CELLS;
                r_pass     <= i_step_budget;
                r_clr_addr <= '0;
            end
            if (i_cmd_dp.clr_step) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cmd_dp.srch_init) begin
                r_cells <= (32'(area) > MAX_CELLS) ? CW'(MAX_CELLS) : CW'(area);
                r_head  <= '0;
                r_tail  <= '0;
                r_end   <= '0;
                r_count <= '0;
                r_rem   <= start_idx;
                r_row   <= '0;
            end
            if (i_cmd_dp.div_step) begin
                r_rem <= r_rem - AW'(w);
                r_row <= r_row + RW'(1);
            end
            if (i_cmd_dp.seed) r_tail <= CW'(1);
            if (i_cmd_dp.pass_begin) r_end <= r_tail;
            if (i_cmd_dp.pass_end) r_pass <= r_pass - STEPS_W'(1);
            if (i_cmd_dp.pop_rd) begin
                r_head <= r_head + CW'(1);
                r_k    <= '0;
            end
            if (i_cmd_dp.nb_eval) r_k <= r_k + 2'd1;
            if (claim) begin
                r_tail  <= r_tail + CW'(1);
                r_count <= r_count + COUNT_W'(1);
            end
        end
    end

    // Status toward the controller.
    assign o_stat.clr_last  = 32'(r_clr_addr) == MAX_CELLS - 1;
    assign o_stat.div_done  = 32'(r_rem) < 32'(w);
    assign o_stat.start_ok  = 32'(r_req_cell) < 32'(r_cells);
    assign o_stat.pass_zero = r_pass == '0;
    assign o_stat.q_empty   = r_head == r_tail;
    assign o_stat.pass_done = r_head == r_end;
    assign o_stat.k_last    = r_k == 2'd3;

    // Output word register.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd_dp.out_sel)
            OUT_ZERO, OUT_SEARCH: begin
                o_reached       <= 1'b0;
                o_steps_left    <= '0;
                o_parent_cell   <= '0;
                o_back_side     <= '0;
                o_reached_count <= (i_cmd_dp.out_sel == OUT_SEARCH) ? r_count : '0;
            end
            OUT_READ: begin
                o_reached_count <= '0;
                if (r_req_in && r_rec_q[REC_R]) begin
                    o_reached     <= 1'b1;
                    o_steps_left  <= r_rec_q[REC_S -: STEPS_W];
                    o_parent_cell <= CELL_W'(r_rec_q[REC_P -: AW]);
                    o_back_side   <= r_rec_q[BACK_W-1:0];
                end else begin
                    o_reached     <= 1'b0;
                    o_steps_left  <= '0;
                    o_parent_cell <= '0;
                    o_back_side   <= '0;
                end
            end
            default: ;
        endcase
    end

    // Queue pointers stay ordered.
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    a_end_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_end || i_cmd_dp.srch_init || $past(i_cmd_dp.pop_rd) ||
        r_end == '0)
        else $error("pass end behind queue head");

    // The queue never grows beyond the board.
    a_tail_le_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= r_cells)
        else $error("more cells queued than the board holds");

endmodule
